>>> src/kmsr_pkg.sv
`timescale 1ns / 1ps

package kmsr_pkg;

	localparam int ROWS    = 6;
	localparam int COLUMNS = 10;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 4;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int BYTE_W  = 8;

	localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] column_index;
		logic             first_read;
		logic             second_read;
	} sample_t;

	typedef struct packed {
		byte_t modifier_bits;
		byte_t key_code;
	} report_t;

	typedef enum logic [1:0] {
		ROLE_KEY,
		ROLE_MOD,
		ROLE_LAYER,
		ROLE_NONE
	} role_t;

	localparam byte_t BASE_MAP [CELLS] = '{
		8'h50, 8'h51, 8'h4F, 8'h52, 8'h00, 8'h29, 8'h76, 8'h28, 8'h2A, 8'hBB,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h2A,
		8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h13,
		8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h28,
		8'h02, 8'h2B, 8'h04, 8'h01, 8'h2C, 8'h2C, 8'h10, 8'h40, 8'h94, 8'h20
	};

	localparam byte_t LAYER_KEY_MAP [CELLS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
		8'h00, 8'h00, 8'h00, 8'h35, 8'h35, 8'h2D, 8'h2E, 8'h2D, 8'h2E, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h2F, 8'h30, 8'h2F, 8'h30, 8'h31, 8'h31, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h33, 8'h33, 8'h34, 8'h34, 8'h38, 8'h38, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam byte_t LAYER_MOD_MAP [CELLS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	function automatic logic in_range(input sample_t s);
		return (s.row_index < ROW_LIMIT) && (s.column_index < COL_LIMIT);
	endfunction

	function automatic cell_t cell_of(input sample_t s);
		return CELL_W'(32'(s.row_index) * COLUMNS + 32'(s.column_index));
	endfunction

	function automatic logic is_report_cell(input sample_t s);
		return (s.row_index == LAST_ROW) && (s.column_index == LAST_COL);
	endfunction

	function automatic role_t bottom_role(input logic [COL_W-1:0] col);
		role_t role;
		case (col)
			4'd2, 4'd3, 4'd6, 4'd7, 4'd9: role = ROLE_MOD;
			4'd0:                         role = ROLE_LAYER;
			4'd8:                         role = ROLE_NONE;
			default:                      role = ROLE_KEY;
		endcase
		return role;
	endfunction

endpackage

>>> src/kmsr_in_if.sv
`timescale 1ns / 1ps

interface kmsr_in_if;
	logic                         valid;
	logic                         ready;
	logic [kmsr_pkg::ROW_W-1:0]   row_index;
	logic [kmsr_pkg::COL_W-1:0]   column_index;
	logic                         first_read;
	logic                         second_read;

	modport source (
		output valid, row_index, column_index, first_read, second_read,
		input  ready
	);
	modport sink (
		input  valid, row_index, column_index, first_read, second_read,
		output ready
	);
endinterface

>>> src/kmsr_out_if.sv
`timescale 1ns / 1ps

interface kmsr_out_if;
	logic                  valid;
	logic                  ready;
	kmsr_pkg::byte_t       modifier_bits;
	kmsr_pkg::byte_t       key_code;

	modport source (
		output valid, modifier_bits, key_code,
		input  ready
	);
	modport sink (
		input  valid, modifier_bits, key_code,
		output ready
	);
endinterface

>>> src/kmsr_ram.sv
`timescale 1ns / 1ps

module kmsr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/kmsr_debounce.sv
`timescale 1ns / 1ps

module kmsr_debounce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  kmsr_pkg::cell_t     rd_cell,
	input  logic                wr_en,
	input  kmsr_pkg::cell_t     wr_cell,
	input  logic                first_read,
	input  logic                second_read,
	output logic                pressed
);

	logic [kmsr_pkg::CELLS-1:0] written_q;
	logic                       ram_rd;
	logic                       byp_q;
	logic                       byp_bit_q;
	logic                       old_bit;

	kmsr_ram #(
		.WIDTH (1),
		.DEPTH (kmsr_pkg::CELLS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_cell),
		.wdata (pressed),
		.re    (rd_en),
		.raddr (rd_cell),
		.rdata (ram_rd)
	);

	always_comb begin
		if (byp_q) begin
			old_bit = byp_bit_q;
		end else begin
			old_bit = written_q[wr_cell] & ram_rd;
		end
		if (first_read == second_read) begin
			pressed = ~first_read;
		end else begin
			pressed = old_bit;
		end
	end

	// forward a write that lands in the same cycle as the read of that cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			byp_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_cell] <= 1'b1;
			end
			if (rd_en) begin
				byp_q <= wr_en && (rd_cell == wr_cell);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_bit_q <= pressed;
		end
	end

endmodule

>>> src/kmsr_report.sv
`timescale 1ns / 1ps

module kmsr_report (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                pressed,
	input  kmsr_pkg::sample_t   sample,
	input  kmsr_pkg::cell_t     cell_idx,
	output kmsr_pkg::report_t   rpt
);

	kmsr_pkg::byte_t mod_q;
	kmsr_pkg::byte_t key_q;
	logic            layer_q;
	kmsr_pkg::byte_t mod_n;
	kmsr_pkg::byte_t key_n;
	logic            layer_n;

	always_comb begin
		mod_n   = mod_q;
		key_n   = key_q;
		layer_n = layer_q;
		if (pressed) begin
			if (sample.row_index == kmsr_pkg::LAST_ROW) begin
				case (kmsr_pkg::bottom_role(sample.column_index))
					kmsr_pkg::ROLE_MOD:   mod_n   = kmsr_pkg::BASE_MAP[cell_idx];
					kmsr_pkg::ROLE_LAYER: layer_n = 1'b1;
					kmsr_pkg::ROLE_KEY:   key_n   = kmsr_pkg::BASE_MAP[cell_idx];
					default: ;
				endcase
			end else if (!layer_q) begin
				key_n = kmsr_pkg::BASE_MAP[cell_idx];
			end else begin
				mod_n   = kmsr_pkg::LAYER_MOD_MAP[cell_idx];
				key_n   = kmsr_pkg::LAYER_KEY_MAP[cell_idx];
				layer_n = 1'b0;
			end
		end
	end

	assign rpt.modifier_bits = mod_n;
	assign rpt.key_code      = key_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q   <= '0;
			key_q   <= '0;
			layer_q <= 1'b0;
		end else if (fire) begin
			layer_q <= layer_n;
			if (kmsr_pkg::is_report_cell(sample)) begin
				mod_q <= '0;
				key_q <= '0;
			end else begin
				mod_q <= mod_n;
				key_q <= key_n;
			end
		end
	end

endmodule

>>> src/key_matrix_scan_report_unit.sv
`timescale 1ns / 1ps
// Debounced 6x10 key matrix scanner that builds one keyboard report per scan.
// sample: one matrix cell per beat (row, column, two reads of the row line, low
//   means closed). Cells outside the matrix are dropped without effect.
// report: one beat per pass over the last cell of the bottom row, carrying the
//   modifier byte and key code gathered since the previous report.
// Throughput: one sample per cycle unless sample.ready drops (see Stall), set by
//   a one-read one-write state RAM read at accept and written back from the sample stage with a forwarding path.
// Pipeline: a report beat comes from its sample through the sample register,
//   then the report register.
// Reset: all keys read as released, pending bytes and the layer are cleared;
//   no RAM sweep is needed, per-cell written flags mask stale contents.
// Stall: a held report beat does not block samples that produce no report;
//   sample.ready drops only when a second report cell waits behind a held
//   report beat.
module key_matrix_scan_report_unit (
	input  logic          clk,
	input  logic          arst_n,
	kmsr_in_if.sink       sample,
	kmsr_out_if.source    report
);

	kmsr_pkg::sample_t smp_in;
	kmsr_pkg::sample_t smp_s1;
	logic              vld_s1;
	logic              accept;
	logic              fire_s1;
	logic              hit_s1;
	logic              rpt_s1;
	logic              pressed_s1;
	kmsr_pkg::cell_t   cell_s1;
	kmsr_pkg::report_t rpt_next;
	logic              out_vld_q;
	kmsr_pkg::report_t out_q;

	assign smp_in.row_index    = sample.row_index;
	assign smp_in.column_index = sample.column_index;
	assign smp_in.first_read   = sample.first_read;
	assign smp_in.second_read  = sample.second_read;

	assign hit_s1  = vld_s1 && kmsr_pkg::in_range(smp_s1);
	assign rpt_s1  = hit_s1 && kmsr_pkg::is_report_cell(smp_s1);
	assign fire_s1 = vld_s1 && (!rpt_s1 || !out_vld_q || report.ready);
	assign cell_s1 = kmsr_pkg::cell_of(smp_s1);

	assign sample.ready = !vld_s1 || fire_s1;
	assign accept       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample.ready) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= smp_in;
		end
	end

	kmsr_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept && kmsr_pkg::in_range(smp_in)),
		.rd_cell     (kmsr_pkg::cell_of(smp_in)),
		.wr_en       (fire_s1 && hit_s1),
		.wr_cell     (cell_s1),
		.first_read  (smp_s1.first_read),
		.second_read (smp_s1.second_read),
		.pressed     (pressed_s1)
	);

	kmsr_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire_s1 && hit_s1),
		.pressed  (pressed_s1),
		.sample   (smp_s1),
		.cell_idx (cell_s1),
		.rpt      (rpt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire_s1 && rpt_s1) begin
			out_vld_q <= 1'b1;
		end else if (report.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && rpt_s1) begin
			out_q <= rpt_next;
		end
	end

	assign report.valid         = out_vld_q;
	assign report.modifier_bits = out_q.modifier_bits;
	assign report.key_code      = out_q.key_code;

	a_report_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(fire_s1 && rpt_s1))
		else $error("report beat without a report cell");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (vld_s1 && rpt_s1 && out_vld_q && !report.ready))
		else $error("sample stalled without a blocked report");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && rpt_s1) |-> (!out_vld_q || report.ready))
		else $error("held report beat overwritten");

endmodule

>>> test/key_matrix_scan_report_unit_test.sv
`timescale 1ns / 1ps

module key_matrix_scan_report_unit_test;

	localparam int RANDOM_CELLS = 1100;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LAYER_COL    = 0;
	localparam int DEAD_COL     = 8;

	localparam kmsr_pkg::byte_t BASE_CODES [kmsr_pkg::CELLS] = '{
		8'h50, 8'h51, 8'h4F, 8'h52, 8'h00, 8'h29, 8'h76, 8'h28, 8'h2A, 8'hBB,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h2A,
		8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h13,
		8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h28,
		8'h02, 8'h2B, 8'h04, 8'h01, 8'h2C, 8'h2C, 8'h10, 8'h40, 8'h94, 8'h20
	};

	localparam kmsr_pkg::byte_t LAYER_CODES [kmsr_pkg::CELLS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
		8'h00, 8'h00, 8'h00, 8'h35, 8'h35, 8'h2D, 8'h2E, 8'h2D, 8'h2E, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h2F, 8'h30, 8'h2F, 8'h30, 8'h31, 8'h31, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h33, 8'h33, 8'h34, 8'h34, 8'h38, 8'h38, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam kmsr_pkg::byte_t LAYER_MODS [kmsr_pkg::CELLS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	logic clk;
	logic arst_n;

	kmsr_in_if  sample_if ();
	kmsr_out_if report_if ();

	key_matrix_scan_report_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.report (report_if)
	);

	kmsr_pkg::sample_t pending_samples [$];
	kmsr_pkg::report_t expected_reports [$];

	bit              held_keys [kmsr_pkg::CELLS];
	bit              layer_on;
	kmsr_pkg::byte_t mod_acc;
	kmsr_pkg::byte_t key_acc;

	int  matrix_cells;
	int  total_samples;
	int  samples_accepted;
	int  quiet_cycles;
	int  error_count;
	bit  sample_taken;

	function automatic bit scan_cell(input kmsr_pkg::sample_t s,
		output kmsr_pkg::report_t rpt);
		int idx;
		rpt = '0;
		if (s.row_index >= kmsr_pkg::ROWS || s.column_index >= kmsr_pkg::COLUMNS)
			return 1'b0;
		idx = int'(s.row_index) * kmsr_pkg::COLUMNS + int'(s.column_index);
		if (s.first_read == s.second_read)
			held_keys[idx] = !s.first_read;
		if (held_keys[idx]) begin
			if (s.row_index == kmsr_pkg::ROWS - 1) begin
				case (int'(s.column_index))
					2, 3, 6, 7, 9: mod_acc = BASE_CODES[idx];
					LAYER_COL:     layer_on = 1'b1;
					DEAD_COL:      ;
					default:       key_acc = BASE_CODES[idx];
				endcase
			end else if (!layer_on) begin
				key_acc = BASE_CODES[idx];
			end else begin
				mod_acc  = LAYER_MODS[idx];
				key_acc  = LAYER_CODES[idx];
				layer_on = 1'b0;
			end
		end
		if (s.row_index == kmsr_pkg::ROWS - 1 && s.column_index == kmsr_pkg::COLUMNS - 1) begin
			rpt.modifier_bits = mod_acc;
			rpt.key_code      = key_acc;
			mod_acc = '0;
			key_acc = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void queue_cell(input int row, input int col, input bit a, input bit b);
		kmsr_pkg::sample_t s;
		s.row_index    = kmsr_pkg::ROW_W'(row);
		s.column_index = kmsr_pkg::COL_W'(col);
		s.first_read   = a;
		s.second_read  = b;
		pending_samples.push_back(s);
		if (row < kmsr_pkg::ROWS && col < kmsr_pkg::COLUMNS)
			matrix_cells++;
	endfunction

	function automatic void queue_random_reads(input int row, input int col);
		int roll;
		bit a;
		roll = $urandom_range(99);
		if (roll < 55) begin
			queue_cell(row, col, 1'b1, 1'b1);
		end else if (roll < 85) begin
			queue_cell(row, col, 1'b0, 1'b0);
		end else begin
			a = 1'($urandom_range(1));
			queue_cell(row, col, a, !a);
		end
	endfunction

	task automatic build_stimulus();
		int roll;
		int n;
		queue_cell(6, 0, 1'b0, 1'b0);
		queue_cell(7, 15, 1'b0, 1'b0);
		queue_cell(3, 10, 1'b0, 1'b0);
		queue_cell(5, 9, 1'b1, 1'b1);
		queue_cell(5, 2, 1'b0, 1'b0);
		queue_cell(5, 4, 1'b0, 1'b0);
		queue_cell(5, 8, 1'b0, 1'b0);
		queue_cell(5, 9, 1'b0, 1'b0);
		queue_cell(5, 9, 1'b1, 1'b1);
		queue_cell(5, 7, 1'b0, 1'b0);
		queue_cell(0, 9, 1'b0, 1'b0);
		queue_cell(5, 0, 1'b0, 1'b0);
		queue_cell(2, 8, 1'b0, 1'b1);
		queue_cell(2, 8, 1'b0, 1'b0);
		queue_cell(1, 0, 1'b0, 1'b0);
		queue_cell(5, 0, 1'b1, 1'b0);
		queue_cell(5, 9, 1'b1, 1'b1);
		queue_cell(0, 5, 1'b0, 1'b0);
		queue_cell(5, 3, 1'b0, 1'b0);
		queue_cell(5, 6, 1'b0, 1'b1);
		queue_cell(5, 0, 1'b1, 1'b1);
		queue_cell(4, 9, 1'b0, 1'b0);
		queue_cell(5, 9, 1'b1, 1'b1);
		matrix_cells = 0;
		while (matrix_cells < RANDOM_CELLS) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				for (int r = 0; r < kmsr_pkg::ROWS; r++)
					for (int c = 0; c < kmsr_pkg::COLUMNS; c++)
						queue_random_reads(r, c);
			end else if (roll < 85) begin
				n = $urandom_range(1, 10);
				repeat (n) begin
					if ($urandom_range(9) == 0)
						queue_random_reads(kmsr_pkg::ROWS - 1, LAYER_COL);
					else
						queue_random_reads($urandom_range(kmsr_pkg::ROWS - 1),
							$urandom_range(kmsr_pkg::COLUMNS - 1));
				end
				queue_random_reads(kmsr_pkg::ROWS - 1, kmsr_pkg::COLUMNS - 1);
			end else begin
				queue_cell($urandom_range(7), $urandom_range(15), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		int send_idle;
		int take_idle;
		if (arst_n) begin
			if (samples_accepted * 3 < total_samples) begin
				send_idle = 27;
				take_idle = 74;
			end else if (samples_accepted * 3 < total_samples * 2) begin
				send_idle = 74;
				take_idle = 27;
			end else begin
				send_idle = 0;
				take_idle = 0;
			end
			if (!sample_if.valid || sample_taken) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
					kmsr_pkg::sample_t s;
					s = pending_samples.pop_front();
					sample_if.valid        <= 1'b1;
					sample_if.row_index    <= s.row_index;
					sample_if.column_index <= s.column_index;
					sample_if.first_read   <= s.first_read;
					sample_if.second_read  <= s.second_read;
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
			report_if.ready <= ($urandom_range(99) >= take_idle);
		end
	end

	always @(posedge clk) begin
		kmsr_pkg::sample_t s;
		kmsr_pkg::report_t got;
		kmsr_pkg::report_t want;
		bit                sample_beat;
		bit                report_beat;
		sample_beat = arst_n && sample_if.valid && sample_if.ready;
		report_beat = arst_n && report_if.valid && report_if.ready;
		sample_taken <= sample_beat;
		if (report_beat) begin
			got.modifier_bits = report_if.modifier_bits;
			got.key_code      = report_if.key_code;
			if (expected_reports.size() == 0) begin
				$display("%0t: report beat %02h/%02h, expected none", $time,
					got.modifier_bits, got.key_code);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				if (got.modifier_bits !== want.modifier_bits) begin
					$display("%0t: modifier_bits expected %02h actual %02h", $time,
						want.modifier_bits, got.modifier_bits);
					error_count++;
				end
				if (got.key_code !== want.key_code) begin
					$display("%0t: key_code expected %02h actual %02h", $time,
						want.key_code, got.key_code);
					error_count++;
				end
			end
		end
		if (sample_beat) begin
			s.row_index    = sample_if.row_index;
			s.column_index = sample_if.column_index;
			s.first_read   = sample_if.first_read;
			s.second_read  = sample_if.second_read;
			if (scan_cell(s, want))
				expected_reports.push_back(want);
			samples_accepted++;
		end
		if (sample_beat || report_beat || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL key_matrix_scan_report_unit");
		$finish;
	end

	initial begin
		arst_n                 = 1'b0;
		sample_if.valid        = 1'b0;
		sample_if.row_index    = '0;
		sample_if.column_index = '0;
		sample_if.first_read   = 1'b1;
		sample_if.second_read  = 1'b1;
		report_if.ready        = 1'b0;
		build_stimulus();
		total_samples = pending_samples.size();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (pending_samples.size() == 0 && !sample_if.valid && expected_reports.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d report beats expected, never seen", $time,
				expected_reports.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("PASS key_matrix_scan_report_unit");
		end else begin
			$display("FAIL key_matrix_scan_report_unit");
		end
		$finish;
	end

endmodule
